/* sv/gntt_pkg.sv */
// Package for the gated nearest-target tracker.
// Holds word types, register indexes, reset values and the dead-zone function.
// No dependencies.
`timescale 1ns / 1ps

package gntt_pkg;

  localparam int unsigned MAX_DETECTIONS = 31;

  localparam int unsigned CFG_DW = 33;
  localparam int unsigned CFG_IW = 8;

  localparam logic [15:0] CENTRE_Q16 = 16'h8000;
  localparam logic [7:0]  NO_CLASS   = 8'hFF;

  localparam logic [7:0]  TARGET_CLASS_RST = 8'd0;
  localparam logic [32:0] GATE_DIST_SQ_RST = 33'd2748779069;
  localparam logic [15:0] DEAD_ZONE_X_RST  = 16'd7864;
  localparam logic [15:0] DEAD_ZONE_Y_RST  = 16'd13107;

  typedef enum logic [CFG_IW-1:0] {
    CFG_TARGET_CLASS = 8'd0,
    CFG_GATE_DIST_SQ = 8'd1,
    CFG_DEAD_ZONE_X  = 8'd2,
    CFG_DEAD_ZONE_Y  = 8'd3
  } cfg_reg_e;

  typedef logic signed [1:0] cmd_t;

  localparam cmd_t CMD_POS  = 2'sb01;
  localparam cmd_t CMD_HOLD = 2'sb00;
  localparam cmd_t CMD_NEG  = 2'sb11;

  typedef struct packed {
    logic [7:0]  class_id;
    logic [15:0] x_center;
    logic [15:0] y_center;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic        frame_end;
  } det_word_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  sel_class;
    logic [15:0] sel_x;
    logic [15:0] sel_y;
    logic [15:0] sel_width;
    logic [15:0] sel_height;
  } sel_t;

  // +1 above the dead zone, -1 below it, 0 inside (boundary inclusive)
  function automatic cmd_t zone_cmd(logic [15:0] v, logic [15:0] half);
    logic signed [17:0] d;
    logic signed [17:0] h;
    d = signed'({2'b00, v}) - signed'({2'b00, CENTRE_Q16});
    h = signed'({2'b00, half});
    if (d > h) begin
      return CMD_POS;
    end else if (d < -h) begin
      return CMD_NEG;
    end
    return CMD_HOLD;
  endfunction

  function automatic cmd_t cmd_flip(cmd_t c);
    if (c == CMD_POS) begin
      return CMD_NEG;
    end else if (c == CMD_NEG) begin
      return CMD_POS;
    end
    return CMD_HOLD;
  endfunction

endpackage

/* sv/gntt_if.sv */
// Handshake interfaces of the tracker: detection words in, track words out.
// No dependencies.
`timescale 1ns / 1ps

interface det_if;
  logic        valid;
  logic        ready;
  logic [7:0]  class_id;
  logic [15:0] x_center;
  logic [15:0] y_center;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        frame_end;

  modport source (
    output valid, class_id, x_center, y_center, box_width, box_height, frame_end,
    input  ready
  );
  modport sink (
    input  valid, class_id, x_center, y_center, box_width, box_height, frame_end,
    output ready
  );
endinterface

interface trk_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [7:0]        sel_class;
  logic [15:0]       sel_x;
  logic [15:0]       sel_y;
  logic [15:0]       sel_width;
  logic [15:0]       sel_height;
  logic signed [1:0] forward_cmd;
  logic signed [1:0] yaw_cmd;

  modport source (
    output valid, found, sel_class, sel_x, sel_y, sel_width, sel_height,
           forward_cmd, yaw_cmd,
    input  ready
  );
  modport sink (
    input  valid, found, sel_class, sel_x, sel_y, sel_width, sel_height,
           forward_cmd, yaw_cmd,
    output ready
  );
endinterface

/* sv/gntt_in_stage.sv */
// Input register of the tracker: captures one detection word per cycle while empty or advancing.
// Depends on gntt_pkg and det_if.
`timescale 1ns / 1ps

module gntt_in_stage
  import gntt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  det_if.sink       det_i,
  input  logic      adv_i,
  output logic      valid_o,
  output det_word_t word_o
);

  logic      valid_q;
  logic      valid_d;
  det_word_t word_q;
  logic      take;

  assign det_i.ready = !valid_q || adv_i;
  assign take        = det_i.valid && det_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= '{class_id:   det_i.class_id,
                  x_center:   det_i.x_center,
                  y_center:   det_i.y_center,
                  box_width:  det_i.box_width,
                  box_height: det_i.box_height,
                  frame_end:  det_i.frame_end};
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* sv/gntt_assoc.sv */
// Gated nearest-neighbour association: distance to reference, running best,
// per-frame scan state and reference update. Depends on gntt_pkg.
`timescale 1ns / 1ps

module gntt_assoc
  import gntt_pkg::*;
#(
  parameter int unsigned MaxDetections = MAX_DETECTIONS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  det_word_t   item_i,
  input  logic        fire_i,
  input  logic [7:0]  target_class_i,
  input  logic [32:0] gate_i,
  output sel_t        sel_o
);

  localparam int unsigned CntW = $clog2(MaxDetections + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxDetections);

  logic [15:0]     ref_x_q, ref_y_q;
  logic [32:0]     best_dist_q;
  logic [7:0]      best_cls_q;
  logic [15:0]     best_x_q, best_y_q, best_w_q, best_h_q;
  logic            best_valid_q, best_valid_d;
  logic            stopped_q, stopped_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [15:0] dx, dy;
  logic [31:0] sq_x, sq_y;
  logic [32:0] sum_sq;
  logic        active, match, take;

  assign dx   = (item_i.x_center >= ref_x_q) ? item_i.x_center - ref_x_q
                                             : ref_x_q - item_i.x_center;
  assign dy   = (item_i.y_center >= ref_y_q) ? item_i.y_center - ref_y_q
                                             : ref_y_q - item_i.y_center;
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;
  assign sum_sq = {1'b0, sq_x} + {1'b0, sq_y};

  assign active = !stopped_q && (cnt_q != CntMax);
  assign match  = (item_i.class_id == target_class_i);
  assign take   = active && match && (sum_sq <= gate_i)
                  && (!best_valid_q || sum_sq < best_dist_q);

  assign best_valid_d = best_valid_q || take;

  always_comb begin
    sel_o = '{found: 1'b0, sel_class: NO_CLASS, sel_x: '0, sel_y: '0,
              sel_width: '0, sel_height: '0};
    if (take) begin
      sel_o = '{found: 1'b1, sel_class: item_i.class_id,
                sel_x: item_i.x_center, sel_y: item_i.y_center,
                sel_width: item_i.box_width, sel_height: item_i.box_height};
    end else if (best_valid_q) begin
      sel_o = '{found: 1'b1, sel_class: best_cls_q, sel_x: best_x_q, sel_y: best_y_q,
                sel_width: best_w_q, sel_height: best_h_q};
    end
  end

  always_comb begin
    stopped_d = stopped_q || (active && !match);
    cnt_d     = (cnt_q != CntMax) ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q      <= CENTRE_Q16;
      ref_y_q      <= CENTRE_Q16;
      best_valid_q <= 1'b0;
      stopped_q    <= 1'b0;
      cnt_q        <= '0;
    end else if (fire_i) begin
      if (item_i.frame_end) begin
        best_valid_q <= 1'b0;
        stopped_q    <= 1'b0;
        cnt_q        <= '0;
        if (best_valid_d) begin
          ref_x_q <= sel_o.sel_x;
          ref_y_q <= sel_o.sel_y;
        end
      end else begin
        best_valid_q <= best_valid_d;
        stopped_q    <= stopped_d;
        cnt_q        <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && take) begin
      best_dist_q <= sum_sq;
      best_cls_q  <= item_i.class_id;
      best_x_q    <= item_i.x_center;
      best_y_q    <= item_i.y_center;
      best_w_q    <= item_i.box_width;
      best_h_q    <= item_i.box_height;
    end
  end

endmodule

/* sv/gntt_out_stage.sv */
// Result register of the tracker: forms dead-zone commands and holds the
// track word until taken. Depends on gntt_pkg and trk_if.
`timescale 1ns / 1ps

module gntt_out_stage
  import gntt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  sel_t        sel_i,
  input  logic [15:0] dead_zone_x_i,
  input  logic [15:0] dead_zone_y_i,
  output logic        space_o,
  trk_if.source       trk_o
);

  logic valid_q, valid_d;
  sel_t sel_q;
  cmd_t fwd_q, fwd_d;
  cmd_t yaw_q, yaw_d;

  assign space_o = !valid_q || trk_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (trk_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    fwd_d = CMD_HOLD;
    yaw_d = CMD_HOLD;
    if (sel_i.found) begin
      fwd_d = cmd_flip(zone_cmd(sel_i.sel_y, dead_zone_y_i));
      yaw_d = zone_cmd(sel_i.sel_x, dead_zone_x_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sel_q <= sel_i;
      fwd_q <= fwd_d;
      yaw_q <= yaw_d;
    end
  end

  assign trk_o.valid       = valid_q;
  assign trk_o.found       = sel_q.found;
  assign trk_o.sel_class   = sel_q.sel_class;
  assign trk_o.sel_x       = sel_q.sel_x;
  assign trk_o.sel_y       = sel_q.sel_y;
  assign trk_o.sel_width   = sel_q.sel_width;
  assign trk_o.sel_height  = sel_q.sel_height;
  assign trk_o.forward_cmd = fwd_q;
  assign trk_o.yaw_cmd     = yaw_q;

endmodule

/* sv/gated_nearest_target_tracker.sv */
// Top level of the gated nearest-target tracker: configuration registers,
// input register, association logic and result register.
// Depends on gntt_pkg, gntt_if, gntt_in_stage, gntt_assoc, gntt_out_stage.
//
// Takes one detection word per cycle on det_i and, for every word marked
// frame_end, gives one track word on trk_o via the input and result registers:
// the in-gate detection nearest to the reference point (ties keep the earlier
// one), or found = 0 with class 255 when none qualifies. Scanning of a frame
// stops at the first word of another class or after MaxDetections words.
// The squared distance, gate check and running-minimum update are done in the
// logic between the input register and the result register, so the
// sustained rate is one word per clock; only a frame_end word waits, and only
// while the result register still holds a word not yet taken. Write
// configuration only while no word is in flight.
`timescale 1ns / 1ps

module gated_nearest_target_tracker
  import gntt_pkg::*;
#(
  parameter int unsigned MaxDetections = MAX_DETECTIONS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  det_if.sink               det_i,
  trk_if.source             trk_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  logic [7:0]  target_class_q;
  logic [32:0] gate_q;
  logic [15:0] dz_x_q, dz_y_q;

  logic      in_valid;
  det_word_t in_word;
  logic      adv;
  logic      out_space;
  sel_t      sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_class_q <= TARGET_CLASS_RST;
      gate_q         <= GATE_DIST_SQ_RST;
      dz_x_q         <= DEAD_ZONE_X_RST;
      dz_y_q         <= DEAD_ZONE_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_CLASS: target_class_q <= cfg_wdata_i[7:0];
        CFG_GATE_DIST_SQ: gate_q         <= cfg_wdata_i[32:0];
        CFG_DEAD_ZONE_X:  dz_x_q         <= cfg_wdata_i[15:0];
        CFG_DEAD_ZONE_Y:  dz_y_q         <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign adv = in_valid && (!in_word.frame_end || out_space);

  gntt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .det_i   (det_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .word_o  (in_word)
  );

  gntt_assoc #(
    .MaxDetections (MaxDetections)
  ) u_assoc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (in_word),
    .fire_i         (adv),
    .target_class_i (target_class_q),
    .gate_i         (gate_q),
    .sel_o          (sel)
  );

  gntt_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv && in_word.frame_end),
    .sel_i         (sel),
    .dead_zone_x_i (dz_x_q),
    .dead_zone_y_i (dz_y_q),
    .space_o       (out_space),
    .trk_o         (trk_o)
  );

endmodule

/* sv/gntt_checker.sv */
// Port-level checks on the tracker's track words, bound to the top level.
// Depends on gated_nearest_target_tracker and trk_if.
`timescale 1ns / 1ps

module gntt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              found_i,
  input logic [7:0]        sel_class_i,
  input logic [15:0]       sel_x_i,
  input logic [15:0]       sel_y_i,
  input logic [15:0]       sel_width_i,
  input logic [15:0]       sel_height_i,
  input logic signed [1:0] forward_cmd_i,
  input logic signed [1:0] yaw_cmd_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i) && $stable(sel_x_i)
      && $stable(sel_y_i) && $stable(forward_cmd_i) && $stable(yaw_cmd_i))
    else $error("track word changed while stalled");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> sel_class_i == 8'hFF && sel_x_i == 16'd0
      && sel_y_i == 16'd0 && sel_width_i == 16'd0 && sel_height_i == 16'd0
      && forward_cmd_i == 2'sb00 && yaw_cmd_i == 2'sb00)
    else $error("empty track word carries data");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> forward_cmd_i != 2'sb10 && yaw_cmd_i != 2'sb10)
    else $error("illegal command code");

  a_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i && sel_y_i == 16'h8000 && sel_x_i == 16'h8000
      |-> forward_cmd_i == 2'sb00 && yaw_cmd_i == 2'sb00)
    else $error("centred target commands motion");

endmodule

bind gated_nearest_target_tracker gntt_checker u_gntt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (trk_o.valid),
  .out_ready_i   (trk_o.ready),
  .found_i       (trk_o.found),
  .sel_class_i   (trk_o.sel_class),
  .sel_x_i       (trk_o.sel_x),
  .sel_y_i       (trk_o.sel_y),
  .sel_width_i   (trk_o.sel_width),
  .sel_height_i  (trk_o.sel_height),
  .forward_cmd_i (trk_o.forward_cmd),
  .yaw_cmd_i     (trk_o.yaw_cmd)
);
